@@ hw/rtl/tre_pkg.sv @@
package tre_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int TIME_W    = 32;
    localparam int RPM_W     = 24;
    localparam int MAXRPM_W  = 16;
    localparam int FRAC_W    = 8;
    localparam int OUTCOME_W = 2;

    // Microseconds per minute scaled by 2^8 (rpm carries 8 fraction bits).
    localparam int                 MIN_Q8_W          = 34;
    localparam logic [MIN_Q8_W-1:0] MICROS_PER_MIN_Q8 = 34'd15360000000;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STALE    = 2'd2;

    localparam logic [TIME_W-1:0]   DEBOUNCE_RESET = 32'd1000;
    localparam logic [MAXRPM_W-1:0] MAX_RPM_RESET  = 16'd30000;
    localparam logic [TIME_W-1:0]   STALE_RESET    = 32'd1000000;

    // Output word: rpm_q8, interval_us, accept_time_us, reading_pending, zero fill.
    localparam int OUT_FIELDS_W = RPM_W + TIME_W + TIME_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [0:0] {
        CMD_EDGE   = 1'b0,
        CMD_UPDATE = 1'b1
    } command_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_NO_CHANGE = 2'd0,
        OUT_ACCEPTED  = 2'd1,
        OUT_STALE     = 2'd2,
        OUT_REJECTED  = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_CHECK,
        ST_DIV_RPM,
        ST_DIV_INT,
        ST_FINISH
    } state_t;

endpackage

@@ hw/rtl/tre_edge_ring.sv @@
module tre_edge_ring #(
    parameter int SLOTS = tre_pkg::SLOTS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             clear,
    input  logic                             wr_en,
    input  logic [$clog2(SLOTS)-1:0]         wr_addr,
    input  logic [tre_pkg::TIME_W-1:0]       wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(SLOTS)-1:0]         rd_addr,
    output logic [tre_pkg::TIME_W-1:0]       rd_data
);
    import tre_pkg::*;

    // Slot storage; an entry whose valid bit is clear reads as an empty slot (zero).
    logic [TIME_W-1:0] mem [SLOTS];
    logic [SLOTS-1:0]  valid_reg;
    logic [TIME_W-1:0] rd_word_reg;
    logic              rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (clear) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

@@ hw/rtl/tre_serial_div.sv @@
module tre_serial_div #(
    parameter int DIV_W = 40,
    parameter int DSR_W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    // Restoring division, one quotient bit per cycle. The dividend shifts out of
    // the top of quo_reg while quotient bits shift in at the bottom.
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DSR_W]) begin
                rem_next = diff[DSR_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DSR_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dsr_reg <= divisor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hw/rtl/tacho_rpm_estimator.sv @@
// Channel  Direction  Handshake                 Payload
// s_       in         s_tvalid / s_tready       tdata: time_us; tuser: command
// m_       out        m_tvalid / m_tready       tdata: rpm_q8, interval_us,
//                                               accept_time_us, reading_pending
//                                               tuser: outcome
// cfg_     in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Edge word: no result. Update word: a scan of the ring and a compare, then (with two
// or more edges, not stale) the serial rpm division, a second division for the mean
// interval when accepted, and a load of the output register (DIV_W = $clog2(SLOTS + 1)
// + 34, so 39 for 16 slots). Reset is synchronous, active low, and empties the ring
// through its valid bits. A result waits in the output register while edge words
// flow; a later update holds in its last state until that result is taken.
module tacho_rpm_estimator #(
    parameter int SLOTS = tre_pkg::SLOTS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tre_pkg::TIME_W-1:0]        s_tdata,   // [31:0] time_us
    input  logic                              s_tuser,   // [0] command

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [23:0] rpm_q8, [55:24] interval_us, [87:56] accept_time_us,
    // [88] reading_pending, [95:89] zero
    output logic [tre_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [tre_pkg::OUTCOME_W-1:0]     m_tuser,   // [1:0] outcome

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tre_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tre_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tre_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int DIV_W  = CNT_W + MIN_Q8_W;
    localparam int PAD_W  = OUT_TDATA_W - OUT_FIELDS_W;

    // Configuration registers. Writes are taken at any time; an unknown index is
    // simply dropped.
    logic [TIME_W-1:0]   debounce_reg;
    logic [MAXRPM_W-1:0] max_rpm_reg;
    logic [TIME_W-1:0]   stale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            max_rpm_reg  <= MAX_RPM_RESET;
            stale_reg    <= STALE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_DEBOUNCE: debounce_reg <= cfg_data[TIME_W-1:0];
                REG_MAX_RPM:  max_rpm_reg  <= cfg_data[MAXRPM_W-1:0];
                REG_STALE:    stale_reg    <= cfg_data[TIME_W-1:0];
                default:      ;
            endcase
        end
    end

    state_t state_reg, state_next;

    logic [SLOT_W-1:0]    write_slot_reg, write_slot_next;
    logic [TIME_W-1:0]    last_edge_reg, last_edge_next;
    logic [RPM_W-1:0]     rpm_value_reg, rpm_value_next;
    logic [TIME_W-1:0]    mean_interval_reg, mean_interval_next;
    logic [TIME_W-1:0]    accepted_at_reg, accepted_at_next;
    logic                 pending_reg, pending_next;

    // Working registers of one update.
    logic [TIME_W-1:0]    upd_time_reg, upd_time_next;
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TIME_W-1:0]    earliest_reg, earliest_next;
    logic [TIME_W-1:0]    latest_reg, latest_next;
    logic [CNT_W-1:0]     nm1_reg, nm1_next;
    logic [TIME_W-1:0]    span_reg, span_next;
    logic                 is_stale_reg, is_stale_next;
    logic [DIV_W-1:0]     numer_reg, numer_next;
    outcome_t             outcome_reg, outcome_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [OUTCOME_W-1:0]   out_user_reg, out_user_next;

    // Ring and divider hookup.
    logic                 ring_clear;
    logic                 ring_wr_en;
    logic                 ring_rd_en;
    logic [TIME_W-1:0]    ring_rd_data;
    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [TIME_W-1:0]    div_divisor;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quotient;

    logic                 s_fire;
    logic [TIME_W-1:0]    edge_gap;
    logic [TIME_W-1:0]    age;
    logic [DIV_W-1:0]     rpm_limit;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign edge_gap  = s_tdata - last_edge_reg;
    assign age       = upd_time_reg - latest_reg;
    assign rpm_limit = DIV_W'({max_rpm_reg, {FRAC_W{1'b0}}});

    tre_edge_ring #(
        .SLOTS (SLOTS)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (ring_clear),
        .wr_en   (ring_wr_en),
        .wr_addr (write_slot_reg),
        .wr_data (s_tdata),
        .rd_en   (ring_rd_en),
        .rd_addr (scan_idx_reg[SLOT_W-1:0]),
        .rd_data (ring_rd_data)
    );

    tre_serial_div #(
        .DIV_W (DIV_W),
        .DSR_W (TIME_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next         = state_reg;
        write_slot_next    = write_slot_reg;
        last_edge_next     = last_edge_reg;
        rpm_value_next     = rpm_value_reg;
        mean_interval_next = mean_interval_reg;
        accepted_at_next   = accepted_at_reg;
        pending_next       = pending_reg;
        upd_time_next      = upd_time_reg;
        scan_idx_next      = scan_idx_reg;
        count_next         = count_reg;
        earliest_next      = earliest_reg;
        latest_next        = latest_reg;
        nm1_next           = nm1_reg;
        span_next          = span_reg;
        is_stale_next      = is_stale_reg;
        numer_next         = numer_reg;
        outcome_next       = outcome_reg;
        out_valid_next     = out_valid_reg;
        out_data_next      = out_data_reg;
        out_user_next      = out_user_reg;
        ring_clear         = 1'b0;
        ring_wr_en         = 1'b0;
        ring_rd_en         = 1'b0;
        div_start          = 1'b0;
        div_dividend       = numer_reg;
        div_divisor        = span_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == CMD_EDGE) begin
                        // Debounce against the last accepted edge, modulo 2^32.
                        if (edge_gap >= debounce_reg) begin
                            ring_wr_en     = 1'b1;
                            last_edge_next = s_tdata;
                            if (write_slot_reg == SLOT_W'(SLOTS - 1)) begin
                                write_slot_next = '0;
                            end else begin
                                write_slot_next = write_slot_reg + 1'b1;
                            end
                        end
                    end else begin
                        upd_time_next = s_tdata;
                        scan_idx_next = '0;
                        count_next    = '0;
                        earliest_next = '0;
                        latest_next   = '0;
                        outcome_next  = OUT_NO_CHANGE;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // Read address scan_idx goes out this cycle; the slot read in the
                // previous cycle is folded into count, earliest and latest.
                ring_rd_en    = (scan_idx_reg != CNT_W'(SLOTS));
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg != '0 && ring_rd_data != '0) begin
                    count_next = count_reg + 1'b1;
                    if (earliest_reg == '0 || ring_rd_data < earliest_reg) begin
                        earliest_next = ring_rd_data;
                    end
                    if (ring_rd_data > latest_reg) begin
                        latest_next = ring_rd_data;
                    end
                end
                if (scan_idx_reg == CNT_W'(SLOTS)) begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL: begin
                // Distinct earliest and latest implies at least two filled slots.
                if (latest_reg != earliest_reg) begin
                    nm1_next      = count_reg - 1'b1;
                    span_next     = latest_reg - earliest_reg;
                    is_stale_next = (age > stale_reg);
                    numer_next    = DIV_W'(count_reg - 1'b1) * DIV_W'(MICROS_PER_MIN_Q8);
                    state_next    = ST_CHECK;
                end else begin
                    state_next = ST_FINISH;
                end
            end

            ST_CHECK: begin
                if (is_stale_reg) begin
                    ring_clear     = 1'b1;
                    rpm_value_next = '0;
                    outcome_next   = OUT_STALE;
                    state_next     = ST_FINISH;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_RPM;
                end
            end

            ST_DIV_RPM: begin
                if (div_done) begin
                    if (div_quotient <= rpm_limit) begin
                        rpm_value_next = div_quotient[RPM_W-1:0];
                        div_start      = 1'b1;
                        div_dividend   = DIV_W'(span_reg);
                        div_divisor    = TIME_W'(nm1_reg);
                        state_next     = ST_DIV_INT;
                    end else begin
                        outcome_next = OUT_REJECTED;
                        state_next   = ST_FINISH;
                    end
                end
            end

            ST_DIV_INT: begin
                if (div_done) begin
                    mean_interval_next = div_quotient[TIME_W-1:0];
                    accepted_at_next   = upd_time_reg;
                    pending_next       = 1'b1;
                    outcome_next       = OUT_ACCEPTED;
                    state_next         = ST_FINISH;
                end
            end

            ST_FINISH: begin
                // Load the output register once the previous result is gone.
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{PAD_W{1'b0}}, pending_reg, accepted_at_reg,
                                      mean_interval_reg, rpm_value_reg};
                    out_user_next  = outcome_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            write_slot_reg    <= '0;
            last_edge_reg     <= '0;
            rpm_value_reg     <= '0;
            mean_interval_reg <= '0;
            accepted_at_reg   <= '0;
            pending_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
            scan_idx_reg      <= '0;
            count_reg         <= '0;
            outcome_reg       <= OUT_NO_CHANGE;
        end else begin
            state_reg         <= state_next;
            write_slot_reg    <= write_slot_next;
            last_edge_reg     <= last_edge_next;
            rpm_value_reg     <= rpm_value_next;
            mean_interval_reg <= mean_interval_next;
            accepted_at_reg   <= accepted_at_next;
            pending_reg       <= pending_next;
            out_valid_reg     <= out_valid_next;
            scan_idx_reg      <= scan_idx_next;
            count_reg         <= count_next;
            outcome_reg       <= outcome_next;
        end
    end

    always_ff @(posedge aclk) begin
        upd_time_reg  <= upd_time_next;
        earliest_reg  <= earliest_next;
        latest_reg    <= latest_next;
        nm1_reg       <= nm1_next;
        span_reg      <= span_next;
        is_stale_reg  <= is_stale_next;
        numer_reg     <= numer_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
